@@ hdl/bis_pkg.sv @@
// bytecode instruction splitter: shared types, constants and opcode length table
// no dependencies; imported by every module of the block
`default_nettype none

package bis_pkg;

  // width of stream offsets and the garbage count (range 16 to 32)
  localparam int OffsetWidth = 32;

  localparam int NumOpcodes = 77;
  localparam int FifoDepth  = 4;

  // string opcodes carry a little-endian 16-bit payload length at prefix end
  localparam logic [6:0] OpStrA = 7'd62;
  localparam logic [6:0] OpStrB = 7'd66;

  typedef enum logic [1:0] {
    PhOpcode  = 2'd0,
    PhPrefix  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  typedef enum logic {
    KindSpan    = 1'b0,
    KindSummary = 1'b1
  } result_kind_e;

  // one input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_word_t;

  // one result word
  typedef struct packed {
    result_kind_e result_kind;
    logic [6:0]   span_opcode;
    logic [31:0]  span_offset;
    logic [16:0]  span_len;
    logic         parse_clean;
    logic [31:0]  garbage_bytes;
    logic         final_result;
  } result_t;

  // parser to queue: up to two result words per input word
  typedef struct packed {
    logic [1:0] push_count;
    result_t    res0;
    result_t    res1;
  } parse_out_t;

  // queue status towards the input stage
  typedef struct packed {
    logic room_for_two;
    logic not_empty;
  } fifo_status_t;

  // fixed instruction lengths, opcode order from 0
  localparam logic [4:0] FixedLenTable [NumOpcodes] = '{
    5'd1,  5'd6,  5'd6,  5'd2,  5'd6,  5'd8,  5'd6,  5'd6,  5'd10, 5'd5,
    5'd11, 5'd11, 5'd10, 5'd11, 5'd10, 5'd11, 5'd15, 5'd15, 5'd15, 5'd16,
    5'd16, 5'd16, 5'd15, 5'd15, 5'd16, 5'd16, 5'd10, 5'd11, 5'd7,  5'd7,
    5'd6,  5'd11, 5'd11, 5'd11, 5'd7,  5'd7,  5'd11, 5'd11, 5'd11, 5'd11,
    5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd5,  5'd6,  5'd5,  5'd6,  5'd11, 5'd11, 5'd6,  5'd6,
    5'd11, 5'd7,  5'(1 + 4 + 2), 5'd5, 5'd6, 5'd6, 5'(1 + 4 + 1 + 2), 5'd6, 5'd11, 5'd11,
    5'd10, 5'd10, 5'd11, 5'd10, 5'd11, 5'd6,  5'd11
  };

  // table lookup, opcodes outside the table give one byte
  function automatic logic [4:0] fixed_len(input logic [6:0] op);
    logic [4:0] len;
    len = 5'd1;
    if (op < 7'(NumOpcodes)) begin
      len = FixedLenTable[op];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bis_parser.sv @@
// bytecode instruction splitter: span state and per-byte parse logic
// depends on bis_pkg
`default_nettype none

module bis_parser
  import bis_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire in_word_t   word_i,
  output parse_out_t      out_o
);

  logic [OffsetWidth-1:0] pos_q, pos_d;
  logic [OffsetWidth-1:0] start_q, start_d;
  logic [6:0]             op_q, op_d;
  logic [16:0]            left_q, left_d;
  logic [16:0]            total_q, total_d;
  logic [7:0]             low_q, low_d;
  phase_e                 phase_q, phase_d;
  logic                   failed_q, failed_d;

  logic                   done;
  logic                   is_string;
  logic [15:0]            str_len;
  logic [4:0]             flen;
  logic                   clean;
  logic [OffsetWidth-1:0] garbage;
  result_t                span_res;
  result_t                sum_res;

  assign is_string = (op_q == OpStrA) || (op_q == OpStrB);
  assign str_len   = {word_i.data_byte, low_q};
  assign flen      = fixed_len(word_i.data_byte[6:0]);

  // parse step for one byte
  always_comb begin
    pos_d    = pos_q;
    start_d  = start_q;
    op_d     = op_q;
    left_d   = left_q;
    total_d  = total_q;
    low_d    = low_q;
    phase_d  = phase_q;
    failed_d = failed_q;
    done     = 1'b0;
    if (!failed_q) begin
      unique case (phase_q)
        PhPrefix: begin
          if (is_string && left_q == 17'd2) begin
            low_d = word_i.data_byte;
          end
          if (is_string && left_q == 17'd1) begin
            total_d = total_q + {1'b0, str_len};
            if (str_len != 16'd0) begin
              left_d  = {1'b0, str_len};
              phase_d = PhPayload;
            end else begin
              left_d = '0;
              done   = 1'b1;
            end
          end else if (left_q <= 17'd1) begin
            left_d = '0;
            done   = 1'b1;
          end else begin
            left_d = left_q - 17'd1;
          end
        end
        PhPayload: begin
          if (left_q <= 17'd1) begin
            left_d = '0;
            done   = 1'b1;
          end else begin
            left_d = left_q - 17'd1;
          end
        end
        default: begin
          start_d = pos_q;
          if (word_i.data_byte >= 8'(NumOpcodes)) begin
            failed_d = 1'b1;
            phase_d  = PhOpcode;
          end else begin
            op_d    = word_i.data_byte[6:0];
            total_d = {12'd0, flen};
            left_d  = {12'd0, flen} - 17'd1;
            low_d   = '0;
            if (flen == 5'd1) begin
              done = 1'b1;
            end else begin
              phase_d = PhPrefix;
            end
          end
        end
      endcase
      if (done) begin
        phase_d = PhOpcode;
      end
    end
  end

  // summary figures on the final byte
  assign clean   = !failed_d && (phase_d == PhOpcode);
  assign garbage = clean ? '0 : (pos_q - start_d + {{(OffsetWidth-1){1'b0}}, 1'b1});

  always_comb begin
    span_res               = '0;
    span_res.result_kind   = KindSpan;
    span_res.span_opcode   = op_d;
    span_res.span_offset   = 32'(start_d);
    span_res.span_len      = total_d;
    sum_res                = '0;
    sum_res.result_kind    = KindSummary;
    sum_res.parse_clean    = clean;
    sum_res.garbage_bytes  = 32'(garbage);
    sum_res.final_result   = 1'b1;
  end

  // result words handed to the queue
  always_comb begin
    out_o = '0;
    if (en_i) begin
      if (done) begin
        out_o.res0 = span_res;
        out_o.res1 = sum_res;
        out_o.push_count = word_i.stream_end ? 2'd2 : 2'd1;
      end else begin
        out_o.res0 = sum_res;
        out_o.res1 = sum_res;
        out_o.push_count = word_i.stream_end ? 2'd1 : 2'd0;
      end
    end
  end

  // state update, back to reset values after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      start_q  <= '0;
      op_q     <= '0;
      left_q   <= '0;
      total_q  <= '0;
      low_q    <= '0;
      phase_q  <= PhOpcode;
      failed_q <= 1'b0;
    end else if (en_i) begin
      if (word_i.stream_end) begin
        pos_q    <= '0;
        start_q  <= '0;
        op_q     <= '0;
        left_q   <= '0;
        total_q  <= '0;
        low_q    <= '0;
        phase_q  <= PhOpcode;
        failed_q <= 1'b0;
      end else begin
        pos_q    <= pos_d + {{(OffsetWidth-1){1'b0}}, 1'b1};
        start_q  <= start_d;
        op_q     <= op_d;
        left_q   <= left_d;
        total_q  <= total_d;
        low_q    <= low_d;
        phase_q  <= phase_d;
        failed_q <= failed_d;
      end
    end
  end

`ifndef SYNTHESIS
  // inside a span there is always at least one byte owed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhOpcode) |-> (left_q != 17'd0))
    else $error("span in progress with nothing owed");

  // once failed, the parser never leaves opcode phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (phase_q == PhOpcode))
    else $error("failed parser left opcode phase");

  // two results only come from the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.push_count == 2'd2) |-> (en_i && word_i.stream_end))
    else $error("two results without stream end");

  // after the final byte the stream restarts at offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && word_i.stream_end) |=> (pos_q == '0 && !failed_q))
    else $error("state not cleared after stream end");
`endif

endmodule

`default_nettype wire

@@ hdl/bis_out_fifo.sv @@
// bytecode instruction splitter: result queue, up to two writes and one read per cycle
// depends on bis_pkg
`default_nettype none

module bis_out_fifo
  import bis_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire parse_out_t push_i,
  input  wire logic       pop_i,
  output result_t         head_o,
  output fifo_status_t    status_o
);

  localparam int PtrWidth = $clog2(FifoDepth);
  localparam int CntWidth = $clog2(FifoDepth + 1);

  result_t               slots_q [FifoDepth];
  logic [PtrWidth-1:0]   wr_q, rd_q;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [PtrWidth-1:0]   wr_next;
  logic                  do_pop;

  assign wr_next = wr_q + {{(PtrWidth-1){1'b0}}, 1'b1};
  assign do_pop  = pop_i && (count_q != '0);

  assign head_o                = slots_q[rd_q];
  assign status_o.not_empty    = (count_q != '0);
  assign status_o.room_for_two = (count_q <= CntWidth'(FifoDepth - 2));

  always_comb begin
    count_d = count_q + CntWidth'(push_i.push_count) - CntWidth'(do_pop);
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i.push_count != 2'd0) begin
      slots_q[wr_q] <= push_i.res0;
    end
    if (push_i.push_count == 2'd2) begin
      slots_q[wr_next] <= push_i.res1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrWidth'(push_i.push_count);
      rd_q    <= rd_q + PtrWidth'(do_pop);
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  // fill level never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(FifoDepth))
    else $error("result queue overflow");

  // writes only arrive when two slots are free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push_count != 2'd0) |-> status_o.room_for_two)
    else $error("push into full result queue");

  // an undisturbed queue holds its level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push_count == 2'd0 && !do_pop) |=> $stable(count_q))
    else $error("fill level moved without push or pop");
`endif

endmodule

`default_nettype wire

@@ hdl/bytecode_instruction_splitter_top.sv @@
// path: input register, then parser, whose results are written into the queue
// throughput: one byte per cycle unless stalled; a span-closing final byte yields two words
// output side: results leave a four-word queue at one word per cycle unless out_stall_i
// reset: asynchronous active low, clears the parser state and empties the queue
// bytecode instruction splitter top level: input register, parser, result queue
// depends on bis_pkg, bis_parser and bis_out_fifo
`default_nettype none

module bytecode_instruction_splitter_top
  import bis_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        stream_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [6:0]       span_opcode_o,
  output logic [31:0]      span_offset_o,
  output logic [16:0]      span_len_o,
  output logic             parse_clean_o,
  output logic [31:0]      garbage_bytes_o,
  output logic             final_result_o
);

  logic         in_valid_q;
  in_word_t     in_word_q;
  logic         advance;
  parse_out_t   parse_out;
  result_t      head;
  fifo_status_t fifo_status;

  // input word moves on when the queue can take two results
  assign advance    = in_valid_q && fifo_status.room_for_two;
  assign in_stall_o = in_valid_q && !fifo_status.room_for_two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q.data_byte  <= data_byte_i;
      in_word_q.stream_end <= stream_end_i;
    end
  end

  bis_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .word_i (in_word_q),
    .out_o  (parse_out)
  );

  bis_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (parse_out),
    .pop_i    (!out_stall_i),
    .head_o   (head),
    .status_o (fifo_status)
  );

  // result word from the queue head
  assign out_valid_o     = fifo_status.not_empty;
  assign result_kind_o   = head.result_kind;
  assign span_opcode_o   = head.span_opcode;
  assign span_offset_o   = head.span_offset;
  assign span_len_o      = head.span_len;
  assign parse_clean_o   = head.parse_clean;
  assign garbage_bytes_o = head.garbage_bytes;
  assign final_result_o  = head.final_result;

endmodule

`default_nettype wire
